[sv/segd_pkg.sv]
// ============================================================================
// segd_pkg
// Shared types, widths and helpers of the segment distance pipeline.
// ============================================================================
`default_nettype none

package segd_pkg;

    localparam int CW         = 16;  // input coordinate width
    localparam int DW         = 17;  // coordinate difference width
    localparam int DOTW       = 35;  // dot product width (signed)
    localparam int WW         = 72;  // determinant / numerator width (signed)
    localparam int OUTW       = 52;  // result width
    localparam int OUT_FRAC   = 16;  // fraction bits of the result
    localparam int REG_ADDR_W = 3;   // APB byte address width

    // register index, taken from paddr[REG_ADDR_W-1:2]
    localparam logic [REG_ADDR_W-3:0] REG_PARALLEL_THRESHOLD = 1'b0;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
    } t_vec;

    typedef struct packed {
        t_vec u;   // a_end - a_start
        t_vec v;   // b_end - b_start
        t_vec w;   // a_start - b_start
    } t_geom;

    typedef struct packed {
        logic signed [DOTW-1:0] a;
        logic signed [DOTW-1:0] b;
        logic signed [DOTW-1:0] c;
        logic signed [DOTW-1:0] d;
        logic signed [DOTW-1:0] e;
    } t_dots;

    typedef struct packed {
        logic signed [WW-1:0] sn;
        logic signed [WW-1:0] sd;
        logic signed [WW-1:0] tn;
        logic signed [WW-1:0] td;
    } t_ratio;

    function automatic logic signed [DOTW-1:0] dot3(input t_vec p, input t_vec q);
        logic signed [2*DW-1:0] px;
        logic signed [2*DW-1:0] py;
        logic signed [2*DW-1:0] pz;
        begin
            px = $signed(p.x) * $signed(q.x);
            py = $signed(p.y) * $signed(q.y);
            pz = $signed(p.z) * $signed(q.z);
            return DOTW'(px) + DOTW'(py) + DOTW'(pz);
        end
    endfunction

endpackage

`default_nettype wire

[sv/segd_dots.sv]
// ============================================================================
// segd_dots
// Two stages: direction and offset vectors, then the five dot products.
// ============================================================================
`default_nettype none

module segd_dots
    import segd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_vld,
    input  wire logic signed [CW-1:0] i_a_start_x,
    input  wire logic signed [CW-1:0] i_a_start_y,
    input  wire logic signed [CW-1:0] i_a_start_z,
    input  wire logic signed [CW-1:0] i_a_end_x,
    input  wire logic signed [CW-1:0] i_a_end_y,
    input  wire logic signed [CW-1:0] i_a_end_z,
    input  wire logic signed [CW-1:0] i_b_start_x,
    input  wire logic signed [CW-1:0] i_b_start_y,
    input  wire logic signed [CW-1:0] i_b_start_z,
    input  wire logic signed [CW-1:0] i_b_end_x,
    input  wire logic signed [CW-1:0] i_b_end_y,
    input  wire logic signed [CW-1:0] i_b_end_z,
    output logic                      o_vld,
    output t_geom                     o_geom,
    output t_dots                     o_dots
);

    logic  r_vld1;
    t_geom r_geom1;
    t_geom n_geom1;
    logic  r_vld2;
    t_geom r_geom2;
    t_dots r_dots2;
    t_dots n_dots2;

    always_comb begin
        n_geom1.u.x = DW'(i_a_end_x)   - DW'(i_a_start_x);
        n_geom1.u.y = DW'(i_a_end_y)   - DW'(i_a_start_y);
        n_geom1.u.z = DW'(i_a_end_z)   - DW'(i_a_start_z);
        n_geom1.v.x = DW'(i_b_end_x)   - DW'(i_b_start_x);
        n_geom1.v.y = DW'(i_b_end_y)   - DW'(i_b_start_y);
        n_geom1.v.z = DW'(i_b_end_z)   - DW'(i_b_start_z);
        n_geom1.w.x = DW'(i_a_start_x) - DW'(i_b_start_x);
        n_geom1.w.y = DW'(i_a_start_y) - DW'(i_b_start_y);
        n_geom1.w.z = DW'(i_a_start_z) - DW'(i_b_start_z);
    end

    always_comb begin
        n_dots2.a = dot3(r_geom1.u, r_geom1.u);
        n_dots2.b = dot3(r_geom1.u, r_geom1.v);
        n_dots2.c = dot3(r_geom1.v, r_geom1.v);
        n_dots2.d = dot3(r_geom1.u, r_geom1.w);
        n_dots2.e = dot3(r_geom1.v, r_geom1.w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geom1 <= n_geom1;
            r_geom2 <= r_geom1;
            r_dots2 <= n_dots2;
        end
    end

    assign o_vld  = r_vld2;
    assign o_geom = r_geom2;
    assign o_dots = r_dots2;

endmodule

`default_nettype wire

[sv/segd_clamp.sv]
// ============================================================================
// segd_clamp
// Four stages: cross products, determinant and numerators, clamp of s,
// clamp of t with the matching recompute of s.
// ============================================================================
`default_nettype none

module segd_clamp
    import segd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic [31:0] i_thresh,
    input  wire logic        i_vld,
    input  wire t_geom       i_geom,
    input  wire t_dots       i_dots,
    output logic             o_vld,
    output t_geom            o_geom,
    output t_ratio           o_ratio
);

    localparam int PW = 2 * DOTW;

    // stage 3: products
    logic                 r_vld3;
    t_geom                r_geom3;
    t_dots                r_dots3;
    logic signed [PW-1:0] r_ac, r_bb, r_be, r_cd, r_ae, r_bd;
    // stage 4: determinant and raw numerators
    logic                 r_vld4;
    t_geom                r_geom4;
    t_dots                r_dots4;
    logic signed [WW-1:0] r_det, r_sn0, r_tn0;
    // stage 5: s clamp
    logic                 r_vld5;
    t_geom                r_geom5;
    t_dots                r_dots5;
    t_ratio               r_rat5;
    t_ratio               n_rat5;
    // stage 6: t clamp
    logic                 r_vld6;
    t_geom                r_geom6;
    t_ratio               r_rat6;
    t_ratio               n_rat6;

    logic signed [WW-1:0] thr_w;
    logic signed [WW-1:0] neg_d;
    logic signed [WW-1:0] b_md;
    logic signed [WW-1:0] a_w;

    assign thr_w = $signed({{(WW - 32){1'b0}}, i_thresh});

    always_comb begin
        n_rat5.sn = r_sn0;
        n_rat5.sd = r_det;
        n_rat5.tn = r_tn0;
        n_rat5.td = r_det;
        if (r_det <= thr_w) begin
            // near parallel: pin s to the start of A
            n_rat5.sn = '0;
            n_rat5.sd = WW'(1);
            n_rat5.tn = WW'(r_dots4.e);
            n_rat5.td = WW'(r_dots4.c);
        end else if (r_sn0 < 0) begin
            n_rat5.sn = '0;
            n_rat5.tn = WW'(r_dots4.e);
            n_rat5.td = WW'(r_dots4.c);
        end else if (r_sn0 > r_det) begin
            n_rat5.sn = r_det;
            n_rat5.tn = WW'(r_dots4.e) + WW'(r_dots4.b);
            n_rat5.td = WW'(r_dots4.c);
        end
    end

    assign neg_d = -WW'(r_dots5.d);
    assign b_md  = WW'(r_dots5.b) - WW'(r_dots5.d);
    assign a_w   = WW'(r_dots5.a);

    always_comb begin
        n_rat6 = r_rat5;
        if (r_rat5.tn < 0) begin
            n_rat6.tn = '0;
            if (neg_d < 0) begin
                n_rat6.sn = '0;
            end else if (neg_d > a_w) begin
                n_rat6.sn = r_rat5.sd;
            end else begin
                n_rat6.sn = neg_d;
                n_rat6.sd = a_w;
            end
        end else if (r_rat5.tn > r_rat5.td) begin
            n_rat6.tn = r_rat5.td;
            if (b_md < 0) begin
                n_rat6.sn = '0;
            end else if (b_md > a_w) begin
                n_rat6.sn = r_rat5.sd;
            end else begin
                n_rat6.sn = b_md;
                n_rat6.sd = a_w;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else if (i_en) begin
            r_vld3 <= i_vld;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geom3 <= i_geom;
            r_dots3 <= i_dots;
            r_ac    <= i_dots.a * i_dots.c;
            r_bb    <= i_dots.b * i_dots.b;
            r_be    <= i_dots.b * i_dots.e;
            r_cd    <= i_dots.c * i_dots.d;
            r_ae    <= i_dots.a * i_dots.e;
            r_bd    <= i_dots.b * i_dots.d;
            r_geom4 <= r_geom3;
            r_dots4 <= r_dots3;
            r_det   <= WW'(r_ac) - WW'(r_bb);
            r_sn0   <= WW'(r_be) - WW'(r_cd);
            r_tn0   <= WW'(r_ae) - WW'(r_bd);
            r_geom5 <= r_geom4;
            r_dots5 <= r_dots4;
            r_rat5  <= n_rat5;
            r_geom6 <= r_geom5;
            r_rat6  <= n_rat6;
        end
    end

    assign o_vld   = r_vld6;
    assign o_geom  = r_geom6;
    assign o_ratio = r_rat6;

    // clamped numerators never go negative
    a_num_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld6 |-> (!r_rat6.sn[WW-1] && !r_rat6.tn[WW-1]))
        else $error("negative clamped numerator");

endmodule

`default_nettype wire

[sv/segd_div.sv]
// ============================================================================
// segd_div
// Pipelined restoring divider pair: one quotient bit of s and t per stage.
// ============================================================================
`default_nettype none

module segd_div
    import segd_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire t_geom              i_geom,
    input  wire t_ratio             i_ratio,
    output logic                    o_vld,
    output t_geom                   o_geom,
    output logic [FRAC_BITS:0]      o_sc,
    output logic [FRAC_BITS:0]      o_tc
);

    localparam int QW = FRAC_BITS + 1;
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

    logic          r_vld  [0:FRAC_BITS];
    t_geom         r_geom [0:FRAC_BITS];
    logic [WW-1:0] r_srem [0:FRAC_BITS];
    logic [WW-1:0] r_sden [0:FRAC_BITS];
    logic [QW-1:0] r_sq   [0:FRAC_BITS];
    logic          r_sdn  [0:FRAC_BITS];
    logic [WW-1:0] r_trem [0:FRAC_BITS];
    logic [WW-1:0] r_tden [0:FRAC_BITS];
    logic [QW-1:0] r_tq   [0:FRAC_BITS];
    logic          r_tdn  [0:FRAC_BITS];

    logic s_zero, s_ge, t_zero, t_ge;

    // zero or negative operands give 0; numerator at or above denominator gives 1
    assign s_zero = (i_ratio.sn == 0) || (i_ratio.sd == 0) || i_ratio.sn[WW-1] ||
                    i_ratio.sd[WW-1];
    assign s_ge   = i_ratio.sn >= i_ratio.sd;
    assign t_zero = (i_ratio.tn == 0) || (i_ratio.td == 0) || i_ratio.tn[WW-1] ||
                    i_ratio.td[WW-1];
    assign t_ge   = i_ratio.tn >= i_ratio.td;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geom[0] <= i_geom;
            r_srem[0] <= i_ratio.sn;
            r_sden[0] <= i_ratio.sd;
            r_sdn[0]  <= s_zero || s_ge;
            r_sq[0]   <= (!s_zero && s_ge) ? ONE_Q : '0;
            r_trem[0] <= i_ratio.tn;
            r_tden[0] <= i_ratio.td;
            r_tdn[0]  <= t_zero || t_ge;
            r_tq[0]   <= (!t_zero && t_ge) ? ONE_Q : '0;
        end
    end

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
        logic [WW-1:0] s_sh, t_sh;
        logic          s_bit, t_bit;

        assign s_sh  = r_srem[k-1] << 1;
        assign t_sh  = r_trem[k-1] << 1;
        assign s_bit = s_sh >= r_sden[k-1];
        assign t_bit = t_sh >= r_tden[k-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_geom[k] <= r_geom[k-1];
                r_sden[k] <= r_sden[k-1];
                r_sdn[k]  <= r_sdn[k-1];
                r_tden[k] <= r_tden[k-1];
                r_tdn[k]  <= r_tdn[k-1];
                if (r_sdn[k-1]) begin
                    r_srem[k] <= r_srem[k-1];
                    r_sq[k]   <= r_sq[k-1];
                end else begin
                    r_srem[k] <= s_bit ? (s_sh - r_sden[k-1]) : s_sh;
                    r_sq[k]   <= {r_sq[k-1][QW-2:0], s_bit};
                end
                if (r_tdn[k-1]) begin
                    r_trem[k] <= r_trem[k-1];
                    r_tq[k]   <= r_tq[k-1];
                end else begin
                    r_trem[k] <= t_bit ? (t_sh - r_tden[k-1]) : t_sh;
                    r_tq[k]   <= {r_tq[k-1][QW-2:0], t_bit};
                end
            end
        end
    end

    assign o_vld  = r_vld[FRAC_BITS];
    assign o_geom = r_geom[FRAC_BITS];
    assign o_sc   = r_sq[FRAC_BITS];
    assign o_tc   = r_tq[FRAC_BITS];

    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[FRAC_BITS] |-> (r_sq[FRAC_BITS] <= ONE_Q && r_tq[FRAC_BITS] <= ONE_Q))
        else $error("line parameter above one");

endmodule

`default_nettype wire

[sv/segd_norm.sv]
// ============================================================================
// segd_norm
// Closest-point difference vector and its squared length, five stages.
// ============================================================================
`default_nettype none

module segd_norm
    import segd_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire t_geom              i_geom,
    input  wire logic [FRAC_BITS:0] i_sc,
    input  wire logic [FRAC_BITS:0] i_tc,
    output logic                    o_vld,
    output logic [OUTW-1:0]         o_dist_sq
);

    localparam int PW   = FRAC_BITS + 19;      // signed difference component
    localparam int MW   = FRAC_BITS + 18;      // its magnitude
    localparam int LO   = (MW + 1) / 2;
    localparam int HI   = MW - LO;
    localparam int SQW  = 2 * MW;
    localparam int SUMW = SQW + 2;
    localparam int SH   = 2 * FRAC_BITS - OUT_FRAC;

    logic                 r_vld [0:4];
    logic signed [PW-1:0] r_p   [0:2];
    logic        [MW-1:0] r_mag [0:2];
    logic [2*HI-1:0]      r_hh  [0:2];
    logic [HI+LO-1:0]     r_hl  [0:2];
    logic [2*LO-1:0]      r_ll  [0:2];
    logic [SQW-1:0]       r_sq  [0:2];
    logic [OUTW-1:0]      r_dist;

    logic signed [DW-1:0] u_c [0:2];
    logic signed [DW-1:0] v_c [0:2];
    logic signed [DW-1:0] w_c [0:2];
    logic [SUMW-1:0]      sum;
    logic [SUMW-1:0]      sum_sh;

    assign u_c[0] = i_geom.u.x;
    assign u_c[1] = i_geom.u.y;
    assign u_c[2] = i_geom.u.z;
    assign v_c[0] = i_geom.v.x;
    assign v_c[1] = i_geom.v.y;
    assign v_c[2] = i_geom.v.z;
    assign w_c[0] = i_geom.w.x;
    assign w_c[1] = i_geom.w.y;
    assign w_c[2] = i_geom.w.z;

    for (genvar j = 0; j < 3; j++) begin : g_axis
        logic signed [PW-1:0] su, tv, wf;

        assign su = PW'($signed({1'b0, i_sc})) * PW'(u_c[j]);
        assign tv = PW'($signed({1'b0, i_tc})) * PW'(v_c[j]);
        assign wf = PW'(w_c[j]) <<< FRAC_BITS;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[j]   <= wf + su - tv;
                r_mag[j] <= r_p[j][PW-1] ? MW'(-r_p[j]) : MW'(r_p[j]);
                r_hh[j]  <= r_mag[j][MW-1:LO] * r_mag[j][MW-1:LO];
                r_hl[j]  <= r_mag[j][MW-1:LO] * r_mag[j][LO-1:0];
                r_ll[j]  <= r_mag[j][LO-1:0] * r_mag[j][LO-1:0];
                r_sq[j]  <= (SQW'(r_hh[j]) << (2 * LO)) + (SQW'(r_hl[j]) << (LO + 1)) +
                            SQW'(r_ll[j]);
            end
        end
    end

    assign sum    = SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]);
    assign sum_sh = sum >> SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < 5; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist <= sum_sh[OUTW-1:0];
        end
    end

    assign o_vld     = r_vld[4];
    assign o_dist_sq = r_dist;

endmodule

`default_nettype wire

[sv/segment_segment_distance_sq.sv]
// ============================================================================
// segment_segment_distance_sq
// Squared closest distance between two 3D segments, fully pipelined.
// ============================================================================
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ------------------------------
//  input     in         i_valid / o_ready      i_a_*, i_b_* (12 x s16)
//  output    out        o_valid / i_ready      o_dist_sq (u52, 16 frac bits)
//  config    in         psel/penable/pready    paddr, pwdata, prdata (APB)
//
//  Throughput is one item per cycle while the output is not stalled.
//  The divider retires one quotient bit of both line parameters per stage.
//  Reset (i_rst_n low at a clock edge) empties the pipe and clears the
//  threshold register.
//  A stall at the output freezes every stage at once, so no item is lost
//  or repeated; o_ready is low only while a finished item waits.
//
`default_nettype none

module segment_segment_distance_sq
    import segd_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input items
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic signed [CW-1:0]  i_a_start_x,
    input  wire logic signed [CW-1:0]  i_a_start_y,
    input  wire logic signed [CW-1:0]  i_a_start_z,
    input  wire logic signed [CW-1:0]  i_a_end_x,
    input  wire logic signed [CW-1:0]  i_a_end_y,
    input  wire logic signed [CW-1:0]  i_a_end_z,
    input  wire logic signed [CW-1:0]  i_b_start_x,
    input  wire logic signed [CW-1:0]  i_b_start_y,
    input  wire logic signed [CW-1:0]  i_b_start_z,
    input  wire logic signed [CW-1:0]  i_b_end_x,
    input  wire logic signed [CW-1:0]  i_b_end_y,
    input  wire logic signed [CW-1:0]  i_b_end_z,
    // result items
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [OUTW-1:0]            o_dist_sq,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [REG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic                 en;
    logic [31:0]          r_thresh;
    logic                 cfg_wr;

    logic                 dots_vld;
    t_geom                dots_geom;
    t_dots                dots;
    logic                 clamp_vld;
    t_geom                clamp_geom;
    t_ratio               ratio;
    logic                 div_vld;
    t_geom                div_geom;
    logic [FRAC_BITS:0]   sc;
    logic [FRAC_BITS:0]   tc;

    // advance the whole pipe unless a finished item is held at the output
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // threshold register: written in the APB access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr[REG_ADDR_W-1:2] == REG_PARALLEL_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0;
        end else if (cfg_wr) begin
            r_thresh <= pwdata;
        end
    end

    assign prdata = (paddr[REG_ADDR_W-1:2] == REG_PARALLEL_THRESHOLD) ? r_thresh : '0;

    // stages 1-2: edge vectors and dot products
    segd_dots u_dots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_vld       (i_valid),
        .i_a_start_x (i_a_start_x),
        .i_a_start_y (i_a_start_y),
        .i_a_start_z (i_a_start_z),
        .i_a_end_x   (i_a_end_x),
        .i_a_end_y   (i_a_end_y),
        .i_a_end_z   (i_a_end_z),
        .i_b_start_x (i_b_start_x),
        .i_b_start_y (i_b_start_y),
        .i_b_start_z (i_b_start_z),
        .i_b_end_x   (i_b_end_x),
        .i_b_end_y   (i_b_end_y),
        .i_b_end_z   (i_b_end_z),
        .o_vld       (dots_vld),
        .o_geom      (dots_geom),
        .o_dots      (dots)
    );

    // stages 3-6: determinant, numerators and clamping to segment ends
    segd_clamp u_clamp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_thresh (r_thresh),
        .i_vld    (dots_vld),
        .i_geom   (dots_geom),
        .i_dots   (dots),
        .o_vld    (clamp_vld),
        .o_geom   (clamp_geom),
        .o_ratio  (ratio)
    );

    // FRAC_BITS + 1 stages: both line parameters
    segd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (clamp_vld),
        .i_geom  (clamp_geom),
        .i_ratio (ratio),
        .o_vld   (div_vld),
        .o_geom  (div_geom),
        .o_sc    (sc),
        .o_tc    (tc)
    );

    // five stages: difference vector, squares, sum; last one is the output register
    segd_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_vld     (div_vld),
        .i_geom    (div_geom),
        .i_sc      (sc),
        .i_tc      (tc),
        .o_vld     (o_valid),
        .o_dist_sq (o_dist_sq)
    );

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
